FILE: src/pwalk_pkg.sv
// Shared types and constants for the four-level page table walker.
// No dependencies; used by every module in src.
`timescale 1ns / 1ps

package pwalk_pkg;

  // Field widths
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int DATA_W  = 64;
  localparam int PN_W    = 36;
  localparam int IDX_W   = 9;
  localparam int LEVEL_W = 2;
  localparam int SIZE_W  = 2;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Table levels, top first
  localparam logic [LEVEL_W-1:0] LVL_TOP  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_SEC  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_THR  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_LAST = 2'd3;

  // Page size codes
  localparam logic [SIZE_W-1:0] SIZE_4K = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_2M = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_1G = 2'd2;

  // Entry bit positions
  localparam int BIT_PRESENT = 0;
  localparam int BIT_HUGE    = 7;
  localparam int BASE_LO     = 12;
  localparam int BASE_HI     = 51;

  // One input item
  typedef struct packed {
    logic              cmd;
    logic [VA_W-1:0]   virtual_address;
    logic [DATA_W-1:0] read_data;
  } item_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic [PA_W-1:0]   read_address;
    logic              found;
    logic [DATA_W-1:0] entry;
    logic [SIZE_W-1:0] page_size_code;
  } result_t;

  // Walk state
  typedef struct packed {
    logic               walk_busy;
    logic [LEVEL_W-1:0] walk_level;
    logic [PN_W-1:0]    page_number;
  } walk_state_t;

endpackage

FILE: src/pwalk_step.sv
// One walk step: decodes an item against the walk state, forms the result
// and the next state. Combinational; depends on pwalk_pkg.
`timescale 1ns / 1ps

module pwalk_step (
  input  pwalk_pkg::item_t              item,
  input  pwalk_pkg::walk_state_t        state,
  input  logic [pwalk_pkg::PA_W-1:0]    root_table_base,
  output logic                          res_valid,
  output pwalk_pkg::result_t            res,
  output pwalk_pkg::walk_state_t        state_next
);

  logic [pwalk_pkg::PN_W-1:0]   pn_sel;
  logic [pwalk_pkg::LEVEL_W-1:0] lvl_sel;
  logic [pwalk_pkg::IDX_W-1:0]  idx;
  logic [pwalk_pkg::BASE_HI-pwalk_pkg::BASE_LO:0] base_sel;
  logic present;
  logic huge;

  assign present = item.read_data[pwalk_pkg::BIT_PRESENT];
  assign huge    = item.read_data[pwalk_pkg::BIT_HUGE];

  // Table index for the level being requested
  always_comb begin
    unique case (lvl_sel)
      pwalk_pkg::LVL_TOP: idx = pn_sel[35:27];
      pwalk_pkg::LVL_SEC: idx = pn_sel[26:18];
      pwalk_pkg::LVL_THR: idx = pn_sel[17:9];
      default:            idx = pn_sel[8:0];
    endcase
  end

  // Decode and result selection
  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    pn_sel     = state.page_number;
    lvl_sel    = state.walk_level + 2'd1;
    base_sel   = item.read_data[pwalk_pkg::BASE_HI:pwalk_pkg::BASE_LO];

    res.kind           = pwalk_pkg::KIND_DONE;
    res.read_address   = '0;
    res.found          = 1'b0;
    res.entry          = item.read_data;
    res.page_size_code = pwalk_pkg::SIZE_4K;

    if (item.cmd == pwalk_pkg::CMD_START) begin
      // start: latch page number, ask for the top entry; ignored while busy
      pn_sel   = item.virtual_address[pwalk_pkg::VA_W-1:12];
      lvl_sel  = pwalk_pkg::LVL_TOP;
      base_sel = root_table_base[pwalk_pkg::BASE_HI:pwalk_pkg::BASE_LO];
      if (!state.walk_busy) begin
        res_valid              = 1'b1;
        state_next.walk_busy   = 1'b1;
        state_next.walk_level  = pwalk_pkg::LVL_TOP;
        state_next.page_number = pn_sel;
        res.kind               = pwalk_pkg::KIND_READ;
        res.entry              = '0;
        res.read_address       = {base_sel, idx, 3'b000};
      end
    end else if (state.walk_busy) begin
      res_valid = 1'b1;
      priority if (!present) begin
        state_next.walk_busy  = 1'b0;
        state_next.walk_level = pwalk_pkg::LVL_TOP;
      end else if (state.walk_level == pwalk_pkg::LVL_SEC && huge) begin
        state_next.walk_busy  = 1'b0;
        state_next.walk_level = pwalk_pkg::LVL_TOP;
        res.found             = 1'b1;
        res.page_size_code    = pwalk_pkg::SIZE_1G;
      end else if (state.walk_level == pwalk_pkg::LVL_THR && huge) begin
        state_next.walk_busy  = 1'b0;
        state_next.walk_level = pwalk_pkg::LVL_TOP;
        res.found             = 1'b1;
        res.page_size_code    = pwalk_pkg::SIZE_2M;
      end else if (state.walk_level == pwalk_pkg::LVL_LAST) begin
        state_next.walk_busy  = 1'b0;
        state_next.walk_level = pwalk_pkg::LVL_TOP;
        res.found             = 1'b1;
      end else begin
        // descend; the index is concatenated onto the base, so nothing carries
        state_next.walk_level = lvl_sel;
        res.kind              = pwalk_pkg::KIND_READ;
        res.entry             = '0;
        res.read_address      = {base_sel, idx, 3'b000};
      end
    end
  end

endmodule

FILE: src/pwalk_out_reg.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on pwalk_pkg for the result type.
`timescale 1ns / 1ps

module pwalk_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  pwalk_pkg::result_t            res,
  input  logic                          out_stall,
  output logic                          can_take,
  output logic                          out_valid,
  output pwalk_pkg::result_t            out_res
);

  // Free when empty or when the held result transfers this cycle
  assign can_take = !out_valid || !out_stall;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

FILE: src/four_level_page_table_walker.sv
// Four-level page table walker. An accepted item goes to the input register,
// its result to the result register. Throughput: one item per cycle while
// out_stall is low; the walk state updates in the single step between them.
// Reset (rst, synchronous): idle walk, level 0, page number 0, root base 0,
// both registers empty. Depends on pwalk_pkg, pwalk_step, pwalk_out_reg.
`timescale 1ns / 1ps

module four_level_page_table_walker (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_we,
  input  logic [pwalk_pkg::PA_W-1:0]      cfg_data,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            cmd,
  input  logic [pwalk_pkg::VA_W-1:0]      virtual_address,
  input  logic [pwalk_pkg::DATA_W-1:0]    read_data,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kind,
  output logic [pwalk_pkg::PA_W-1:0]      read_address,
  output logic                            found,
  output logic [pwalk_pkg::DATA_W-1:0]    entry,
  output logic [pwalk_pkg::SIZE_W-1:0]    page_size_code
);

  logic [pwalk_pkg::PA_W-1:0] root_table_base;
  logic                       in_full;
  pwalk_pkg::item_t           in_item;
  pwalk_pkg::walk_state_t     walk_state;
  pwalk_pkg::walk_state_t     walk_state_next;
  pwalk_pkg::result_t         step_res;
  pwalk_pkg::result_t         out_res;
  logic                       step_valid;
  logic                       can_take;
  logic                       advance;

  // Root table base register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_table_base <= '0;
    end else if (cfg_we) begin
      root_table_base <= cfg_data;
    end
  end

  // Input register: the held item steps when the result side is free
  assign advance  = in_full && can_take;
  assign in_stall = in_full && !can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item.cmd             <= cmd;
      in_item.virtual_address <= virtual_address;
      in_item.read_data       <= read_data;
    end
  end

  // Walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_state <= '0;
    end else if (advance) begin
      walk_state <= walk_state_next;
    end
  end

  pwalk_step u_step (
    .item            (in_item),
    .state           (walk_state),
    .root_table_base (root_table_base),
    .res_valid       (step_valid),
    .res             (step_res),
    .state_next      (walk_state_next)
  );

  pwalk_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && step_valid),
    .res       (step_res),
    .out_stall (out_stall),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind           = out_res.kind;
  assign read_address   = out_res.read_address;
  assign found          = out_res.found;
  assign entry          = out_res.entry;
  assign page_size_code = out_res.page_size_code;

  // Checks
  a_idle_level: assert property (@(posedge clk) disable iff (rst)
    !walk_state.walk_busy |-> walk_state.walk_level == pwalk_pkg::LVL_TOP)
    else $error("idle walk with nonzero level");

  a_req_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == pwalk_pkg::KIND_READ |-> !found && entry == '0 &&
    page_size_code == pwalk_pkg::SIZE_4K)
    else $error("read request carries completion fields");

  a_miss_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == pwalk_pkg::KIND_DONE && !found |->
    page_size_code == pwalk_pkg::SIZE_4K && read_address == '0)
    else $error("not-found completion with size or address");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    advance && step_valid && step_res.kind == pwalk_pkg::KIND_READ |=>
    walk_state.walk_busy)
    else $error("read request issued without a walk in progress");

endmodule
